// ----- rtl/mpo_pkg.sv -----
// ----------------------------------------------------------------------------
// mpo_pkg
// Types, codes and feature mapping shared by the online perceptron core.
// ----------------------------------------------------------------------------
package mpo_pkg;

    localparam int CLASS_COUNT  = 3;
    localparam int CLASS_W      = 2;
    localparam int NUM_FEATURES = 8;
    localparam int COUNT_W      = 32;

    typedef enum logic [1:0] {
        ACT_INFER     = 2'd0,
        ACT_TRAIN     = 2'd1,
        ACT_CLEAR_ALL = 2'd2,
        ACT_CLEAR_CNT = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] tool;
        logic       reply_valid;
        logic [7:0] remaining;
        logic       reversal;
        logic       complete;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] predicted_class;
        logic               mispredicted;
        logic [COUNT_W-1:0] miss_count;
    } out_item_t;

    // weight bank update request
    typedef struct packed {
        logic                    en;
        logic                    train;
        logic                    clear;
        logic [CLASS_W-1:0]      tgt;
        logic [CLASS_W-1:0]      pred;
        logic [NUM_FEATURES-1:0] feat;
    } upd_t;

    function automatic logic [NUM_FEATURES-1:0] features(input in_item_t item);
        logic [NUM_FEATURES-1:0] f;
        f    = '0;
        f[0] = 1'b1;
        f[1] = (item.tool == 2'd1);
        f[2] = (item.tool == 2'd2);
        f[3] = (item.tool == 2'd3);
        f[4] = item.reply_valid;
        f[5] = (item.remaining == 8'd0);
        f[6] = item.reversal;
        f[7] = item.complete;
        return f;
    endfunction

endpackage

// ----- rtl/mpo_score.sv -----
// ----------------------------------------------------------------------------
// mpo_score
// Per-class scores over active features and lowest-index argmax.
// ----------------------------------------------------------------------------
module mpo_score
    import mpo_pkg::*;
#(
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic [WEIGHT_WIDTH-1:0] weights [CLASS_COUNT][NUM_FEATURES],
    input  logic [NUM_FEATURES-1:0] feat,
    output logic [CLASS_W-1:0]      pred
);

    localparam int SCORE_W = WEIGHT_WIDTH + $clog2(NUM_FEATURES);

    logic signed [SCORE_W-1:0] term [CLASS_COUNT][NUM_FEATURES];
    logic signed [SCORE_W-1:0] pair [CLASS_COUNT][NUM_FEATURES/2];
    logic signed [SCORE_W-1:0] quad [CLASS_COUNT][NUM_FEATURES/4];
    logic signed [SCORE_W-1:0] score [CLASS_COUNT];
    logic signed [SCORE_W-1:0] top;

    // balanced adder tree per class
    always_comb begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                term[c][f] = feat[f] ? SCORE_W'($signed(weights[c][f])) : '0;
            end
            for (int p = 0; p < NUM_FEATURES/2; p++) begin
                pair[c][p] = term[c][2*p] + term[c][2*p+1];
            end
            for (int q = 0; q < NUM_FEATURES/4; q++) begin
                quad[c][q] = pair[c][2*q] + pair[c][2*q+1];
            end
            score[c] = quad[c][0] + quad[c][1];
        end
    end

    always_comb begin
        pred = '0;
        top  = score[0];
        for (int c = 1; c < CLASS_COUNT; c++) begin
            if (score[c] > top) begin
                top  = score[c];
                pred = CLASS_W'(c);
            end
        end
    end

endmodule

// ----- rtl/mpo_weights.sv -----
// ----------------------------------------------------------------------------
// mpo_weights
// Class weight register bank with perceptron update and clear.
// ----------------------------------------------------------------------------
module mpo_weights
    import mpo_pkg::*;
#(
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  upd_t                    upd,
    output logic [WEIGHT_WIDTH-1:0] weights [CLASS_COUNT][NUM_FEATURES]
);

    logic [WEIGHT_WIDTH-1:0] w_reg  [CLASS_COUNT][NUM_FEATURES];
    logic [WEIGHT_WIDTH-1:0] w_next [CLASS_COUNT][NUM_FEATURES];

    always_comb begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                w_next[c][f] = w_reg[c][f];
                if (upd.en) begin
                    if (upd.clear) begin
                        w_next[c][f] = '0;
                    end else if (upd.train && upd.feat[f]) begin
                        if (upd.tgt == CLASS_W'(c)) begin
                            w_next[c][f] = w_reg[c][f] + WEIGHT_WIDTH'(1);
                        end else if (upd.pred == CLASS_W'(c)) begin
                            w_next[c][f] = w_reg[c][f] - WEIGHT_WIDTH'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                if (!aresetn) begin
                    w_reg[c][f] <= '0;
                end else begin
                    w_reg[c][f] <= w_next[c][f];
                end
            end
        end
    end

    assign weights = w_reg;

endmodule

// ----- rtl/multiclass_perceptron_online_core.sv -----
// ----------------------------------------------------------------------------
// multiclass_perceptron_online_core
// Online three-class perceptron over trace events.
// ----------------------------------------------------------------------------
// Takes one event per cycle while the result is not stalled and returns one
// result per event: the event is registered, scored against all 24 weight
// registers through three adder trees and an argmax in one pass, and the
// result register is loaded while the weights and miss counter update at
// the same edge, so the next event already sees the new weights. A stalled
// result holds one further event in the input register.
module multiclass_perceptron_online_core
    import mpo_pkg::*;
#(
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    in_item_t                in_reg;
    logic                    in_valid_reg, in_valid_next;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]      cnt_reg, cnt_next;

    logic                    advance;
    logic [NUM_FEATURES-1:0] feat;
    logic [CLASS_W-1:0]      pred;
    logic                    tool_ok;
    logic                    miss;
    upd_t                    upd;
    logic [WEIGHT_WIDTH-1:0] weights [CLASS_COUNT][NUM_FEATURES];

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign feat    = features(in_reg);
    assign tool_ok = (in_reg.tool != 2'd0);
    assign miss    = !tool_ok || (pred != (in_reg.tool - 2'd1));

    mpo_score #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_score (
        .weights (weights),
        .feat    (feat),
        .pred    (pred)
    );

    always_comb begin
        upd.en    = advance;
        upd.train = (in_reg.action == ACT_TRAIN) && miss && tool_ok;
        upd.clear = (in_reg.action == ACT_CLEAR_ALL);
        upd.tgt   = in_reg.tool - 2'd1;
        upd.pred  = pred;
        upd.feat  = feat;
    end

    mpo_weights #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_weights (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .weights (weights)
    );

    always_comb begin
        cnt_next = cnt_reg;
        if (advance) begin
            case (in_reg.action) inside
                ACT_INFER, ACT_TRAIN: begin
                    if (miss && (cnt_reg != '1)) begin
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                end
                default: cnt_next = '0;
            endcase
        end
    end

    always_comb begin
        out_next                 = out_reg;
        out_valid_next           = out_valid_reg;
        in_valid_next            = in_valid_reg;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next           = 1'b1;
            in_valid_next            = 1'b0;
            out_next.predicted_class = pred;
            out_next.mispredicted    = miss;
            out_next.miss_count      = cnt_next;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ----- rtl/mpo_checker.sv -----
// ----------------------------------------------------------------------------
// mpo_checker
// Port-level checks for the online perceptron core.
// ----------------------------------------------------------------------------
module mpo_checker
    import mpo_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.predicted_class != 2'd3))
        else $error("predicted class out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("pending input item changed");

endmodule

bind multiclass_perceptron_online_core mpo_checker u_mpo_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the online three-class perceptron core.
// ----------------------------------------------------------------------------
// A queue of trace events (a directed opener, then random events that are
// mostly label-consistent, with some noise and tool-less events) feeds a
// valid/ready driver. Each accepted item runs through a local perceptron
// that keeps its own weights and miss counter. The expected results are
// checked in order against the result channel. Both sides idle at random in
// the first two of three phases but not the last; the receiver holds off
// once for a long stretch so that the core fills up and stalls its input.
module tb;
    import mpo_pkg::*;

    localparam int WEIGHT_WIDTH = 32;
    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASE_A_END  = 620;
    localparam int PHASE_B_END  = 1240;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 60;

    localparam logic [1:0] TOOL_NONE   = 2'd0;
    localparam logic [1:0] TOOL_QUERY  = 2'd1;
    localparam logic [1:0] TOOL_APPLY  = 2'd2;
    localparam logic [1:0] TOOL_COMMIT = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    multiclass_perceptron_online_core #(
        .WEIGHT_WIDTH(WEIGHT_WIDTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    // perceptron state
    logic [WEIGHT_WIDTH-1:0] weights [CLASS_COUNT][NUM_FEATURES];
    logic [COUNT_W-1:0]      misses;

    in_item_t  event_queue [$];
    out_item_t expected_results [$];
    out_item_t want;
    int        sent       = 0;
    int        errors     = 0;
    int        hold_left  = 0;
    logic      hold_done  = 1'b0;
    logic      in_fire    = 1'b0;

    function automatic out_item_t perceptron_step(input in_item_t ev);
        logic [NUM_FEATURES-1:0] f;
        longint                  score [CLASS_COUNT];
        int                      best;
        int                      tgt;
        logic                    miss;
        out_item_t               r;
        f    = '0;
        f[0] = 1'b1;
        f[1] = (ev.tool == TOOL_QUERY);
        f[2] = (ev.tool == TOOL_APPLY);
        f[3] = (ev.tool == TOOL_COMMIT);
        f[4] = ev.reply_valid;
        f[5] = (ev.remaining == 8'd0);
        f[6] = ev.reversal;
        f[7] = ev.complete;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            score[c] = 0;
            for (int k = 0; k < NUM_FEATURES; k++) begin
                if (f[k])
                    score[c] += longint'(signed'(weights[c][k]));
            end
        end
        best = 0;
        for (int c = 1; c < CLASS_COUNT; c++) begin
            if (score[c] > score[best])
                best = c;
        end
        tgt  = int'(ev.tool) - 1;
        miss = (ev.tool == TOOL_NONE) || (best != tgt);
        case (ev.action)
            ACT_INFER, ACT_TRAIN: begin
                if (miss && misses != '1)
                    misses++;
                if (ev.action == ACT_TRAIN && miss && ev.tool != TOOL_NONE) begin
                    for (int k = 0; k < NUM_FEATURES; k++) begin
                        weights[tgt][k]  += WEIGHT_WIDTH'(f[k]);
                        weights[best][k] -= WEIGHT_WIDTH'(f[k]);
                    end
                end
            end
            ACT_CLEAR_ALL: begin
                foreach (weights[c, k])
                    weights[c][k] = '0;
                misses = '0;
            end
            default: begin
                misses = '0;
            end
        endcase
        r.predicted_class = CLASS_W'(best);
        r.mispredicted    = miss;
        r.miss_count      = misses;
        return r;
    endfunction

    task automatic add_event(input action_t act, input logic [1:0] tool, input logic rv,
                             input logic [7:0] rem, input logic rev, input logic comp);
        in_item_t ev;
        ev.action      = act;
        ev.tool        = tool;
        ev.reply_valid = rv;
        ev.remaining   = rem;
        ev.reversal    = rev;
        ev.complete    = comp;
        event_queue.push_back(ev);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (event_queue.size() > 0 &&
                $urandom_range(99) >= ((sent < PHASE_A_END) ? 9 :
                                       (sent < PHASE_B_END) ? 64 : 0)) begin
                s_item  <= event_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= ((sent < PHASE_A_END) ? 64 :
                                               (sent < PHASE_B_END) ? 9 : 0));
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        in_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(perceptron_step(s_item));
                sent <= sent + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, m_item);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.predicted_class !== want.predicted_class) begin
                        errors++;
                        $display("%0t: predicted_class expected %0d actual %0d", $time,
                                 want.predicted_class, m_item.predicted_class);
                    end
                    if (m_item.mispredicted !== want.mispredicted) begin
                        errors++;
                        $display("%0t: mispredicted expected %0d actual %0d", $time,
                                 want.mispredicted, m_item.mispredicted);
                    end
                    if (m_item.miss_count !== want.miss_count) begin
                        errors++;
                        $display("%0t: miss_count expected %0d actual %0d", $time,
                                 want.miss_count, m_item.miss_count);
                    end
                end
            end
        end
    end

    initial begin
        in_item_t ev;
        int       pick;
        foreach (weights[c, k])
            weights[c][k] = '0;
        misses = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opener
        add_event(ACT_INFER,     TOOL_QUERY,  1'b0, 8'd1,   1'b0, 1'b0);
        add_event(ACT_INFER,     TOOL_APPLY,  1'b0, 8'd255, 1'b0, 1'b0);
        add_event(ACT_INFER,     TOOL_COMMIT, 1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_INFER,     TOOL_NONE,   1'b0, 8'd0,   1'b0, 1'b0);
        add_event(ACT_TRAIN,     TOOL_NONE,   1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_TRAIN,     TOOL_APPLY,  1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_TRAIN,     TOOL_COMMIT, 1'b1, 8'd128, 1'b0, 1'b0);
        add_event(ACT_TRAIN,     TOOL_QUERY,  1'b0, 8'd0,   1'b1, 1'b0);
        add_event(ACT_INFER,     TOOL_APPLY,  1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_CLEAR_CNT, TOOL_COMMIT, 1'b0, 8'd127, 1'b0, 1'b1);
        add_event(ACT_INFER,     TOOL_COMMIT, 1'b0, 8'd85,  1'b1, 1'b0);
        add_event(ACT_TRAIN,     TOOL_APPLY,  1'b0, 8'd255, 1'b0, 1'b1);
        add_event(ACT_TRAIN,     TOOL_APPLY,  1'b0, 8'd255, 1'b0, 1'b1);
        add_event(ACT_CLEAR_ALL, TOOL_QUERY,  1'b1, 8'd170, 1'b1, 1'b0);
        add_event(ACT_INFER,     TOOL_APPLY,  1'b0, 8'd0,   1'b0, 1'b0);
        add_event(ACT_TRAIN,     TOOL_COMMIT, 1'b1, 8'd2,   1'b1, 1'b1);
        add_event(ACT_TRAIN,     TOOL_COMMIT, 1'b1, 8'd2,   1'b1, 1'b1);
        add_event(ACT_TRAIN,     TOOL_NONE,   1'b0, 8'd255, 1'b1, 1'b1);
        add_event(ACT_CLEAR_ALL, TOOL_NONE,   1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_CLEAR_CNT, TOOL_APPLY,  1'b1, 8'd0,   1'b1, 1'b1);
        add_event(ACT_INFER,     TOOL_QUERY,  1'b1, 8'd64,  1'b0, 1'b1);

        // random events: mostly label follows the flags, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            ev.action = (pick < 48) ? ACT_TRAIN :
                        (pick < 88) ? ACT_INFER :
                        (pick < 98) ? ACT_CLEAR_CNT : ACT_CLEAR_ALL;
            ev.reply_valid = 1'($urandom_range(1));
            ev.reversal    = 1'($urandom_range(1));
            ev.complete    = 1'($urandom_range(1));
            ev.remaining   = ($urandom_range(99) < 35) ? 8'd0 : 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 5)
                ev.tool = TOOL_NONE;
            else if (pick < 75)
                ev.tool = ev.reversal ? TOOL_COMMIT :
                          (ev.reply_valid || ev.remaining == 8'd0) ? TOOL_APPLY : TOOL_QUERY;
            else
                ev.tool = 2'($urandom_range(3, 1));
            event_queue.push_back(ev);
        end

        while (event_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mpo_pkg.sv
rtl/mpo_score.sv
rtl/mpo_weights.sv
rtl/multiclass_perceptron_online_core.sv
rtl/mpo_checker.sv
tb/sv/tb.sv
